// ----- sv/lcdnws_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnws_pkg
// Shared types and constants of the character-LCD nibble write sequencer.
// ----------------------------------------------------------------------------
package lcdnws_pkg;

	// Number of display columns; goto columns at or above this are rejected.
	localparam int COLUMNS = 20;

	// Request queue between the classifier and the sequencer.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam int CFG_IDX_W = 1;
	localparam int HOLD_W    = 8;

	// Request kinds on the input stream.
	typedef enum logic [2:0] {
		KIND_CMD   = 3'd0,
		KIND_DATA  = 3'd1,
		KIND_GOTO  = 3'd2,
		KIND_INIT  = 3'd3,
		KIND_CLEAR = 3'd4
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CMD_HOLD  = 1'd0,
		REG_DATA_HOLD = 1'd1
	} reg_idx_t;

	localparam logic [HOLD_W-1:0] CMD_HOLD_RESET  = 8'd10;
	localparam logic [HOLD_W-1:0] DATA_HOLD_RESET = 8'd3;

	// LCD command bytes used by several request kinds.
	localparam logic [7:0] LCD_CLEAR    = 8'h01;
	localparam logic [7:0] LCD_SET_ADDR = 8'h80;

	// Byte sequences the back end knows how to play.
	typedef enum logic [1:0] {
		SEQ_BYTE  = 2'd0,
		SEQ_INIT  = 2'd1,
		SEQ_ERROR = 2'd2
	} seq_t;

	// Classified request as it travels through the queue.
	typedef struct packed {
		seq_t       op;
		logic       rs;
		logic [7:0] value;
	} desc_t;

	// Configuration write as seen by the sequencer.
	typedef struct packed {
		logic              we;
		reg_idx_t          index;
		logic [HOLD_W-1:0] data;
	} cfg_wr_t;

	// One bus state, laid out to match the output tdata (reg_select in bit 0).
	typedef struct packed {
		logic              error;
		logic [HOLD_W-1:0] hold_ms;
		logic [3:0]        nibble;
		logic              enable;
		logic              read_write;
		logic              reg_select;
	} bus_state_t;

endpackage
`default_nettype wire

// ----- sv/lcdnws_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnws_front
// Accepts requests and turns each one of a known kind into a sequence descriptor for the queue.
// ----------------------------------------------------------------------------
module lcdnws_front (
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [23:0]        s_tdata,
	input  wire logic               q_full,
	output logic                    push,
	output lcdnws_pkg::desc_t       push_desc
);

	localparam logic [5:0] COL_LIMIT = 6'(lcdnws_pkg::COLUMNS);

	logic [2:0] kind;
	logic [7:0] byte_value;
	logic [2:0] row;
	logic [4:0] column;
	logic       known;
	logic       goto_ok;
	logic [7:0] row_off;

	assign kind       = s_tdata[2:0];
	assign byte_value = s_tdata[10:3];
	assign row        = s_tdata[13:11];
	assign column     = s_tdata[18:14];

	assign s_tready = !q_full;

	always_comb begin
		case (row[1:0])
			2'd0:    row_off = 8'h00;
			2'd1:    row_off = 8'h40;
			2'd2:    row_off = 8'h14;
			default: row_off = 8'h54;
		endcase
	end

	assign goto_ok = !row[2] && ({1'b0, column} < COL_LIMIT);

	always_comb begin
		known           = 1'b1;
		push_desc.op    = lcdnws_pkg::SEQ_BYTE;
		push_desc.rs    = 1'b0;
		push_desc.value = byte_value;
		case (kind)
			lcdnws_pkg::KIND_CMD: begin
			end
			lcdnws_pkg::KIND_DATA: begin
				push_desc.rs = 1'b1;
			end
			lcdnws_pkg::KIND_GOTO: begin
				if (goto_ok) begin
					push_desc.value = 8'(lcdnws_pkg::LCD_SET_ADDR + row_off + {3'b000, column});
				end else begin
					push_desc.op = lcdnws_pkg::SEQ_ERROR;
				end
			end
			lcdnws_pkg::KIND_INIT: begin
				push_desc.op = lcdnws_pkg::SEQ_INIT;
			end
			lcdnws_pkg::KIND_CLEAR: begin
				push_desc.value = lcdnws_pkg::LCD_CLEAR;
			end
			default: begin
				// Unknown kinds are taken and dropped.
				known = 1'b0;
			end
		endcase
	end

	assign push = s_tvalid && s_tready && known;

endmodule
`default_nettype wire

// ----- sv/lcdnws_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnws_queue
// Small descriptor FIFO that decouples the classifier from the sequencer.
// ----------------------------------------------------------------------------
module lcdnws_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire lcdnws_pkg::desc_t  push_desc,
	output logic                    full,
	input  wire logic               pop,
	output logic                    head_valid,
	output lcdnws_pkg::desc_t       head
);

	localparam int AW = lcdnws_pkg::QUEUE_AW;
	localparam logic [AW:0] DEPTH = (AW+1)'(lcdnws_pkg::QUEUE_DEPTH);

	lcdnws_pkg::desc_t mem_q [lcdnws_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   cnt_q;

	assign full       = (cnt_q == DEPTH);
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= AW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= AW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= (AW+1)'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= (AW+1)'(cnt_q - 1'b1);
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH)
		else $error("queue count above depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");

endmodule
`default_nettype wire

// ----- sv/lcdnws_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnws_back
// Plays queued descriptors out as bus states, one state per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module lcdnws_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lcdnws_pkg::cfg_wr_t cfg,
	input  wire logic                head_valid,
	input  wire lcdnws_pkg::desc_t   head,
	output logic                     pop,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [15:0]              m_tdata,
	output logic                     m_tlast
);

	typedef enum logic [1:0] {
		PH_HI_STROBE = 2'd0,
		PH_HI_SETTLE = 2'd1,
		PH_LO_STROBE = 2'd2,
		PH_LO_SETTLE = 2'd3
	} phase_t;

	localparam logic [3:0] INIT_LAST = 4'd4;
	localparam logic [3:0] ERR_LAST  = 4'd9;
	localparam logic [3:0] ERR_TEXT0 = 4'd2;
	localparam logic [7:0] ERR_GOTO  = 8'h85;

	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		case (idx)
			3'd0:    return 8'h02;
			3'd1:    return 8'h28;
			3'd2:    return 8'h0F;
			3'd3:    return 8'h01;
			default: return 8'h06;
		endcase
	endfunction

	function automatic logic [7:0] err_char(input logic [2:0] idx);
		case (idx)
			3'd0:    return 8'h45;
			3'd1:    return 8'h72;
			3'd2:    return 8'h72;
			3'd3:    return 8'h6F;
			3'd4:    return 8'h72;
			3'd5:    return 8'h20;
			default: return 8'h21;
		endcase
	endfunction

	lcdnws_pkg::desc_t       desc_q;
	logic                    active_q;
	phase_t                  phase_q;
	logic [3:0]              byte_idx_q;
	logic [7:0]              cmd_hold_q;
	logic [7:0]              data_hold_q;
	logic                    out_valid_q;
	lcdnws_pkg::bus_state_t  out_data_q;
	logic                    out_last_q;

	logic                    adv;
	logic                    final_st;
	logic [7:0]              cur_byte;
	logic                    cur_rs;
	logic                    cur_err;
	logic [3:0]              last_idx;
	lcdnws_pkg::bus_state_t  nxt_state;

	always_comb begin
		cur_byte = desc_q.value;
		cur_rs   = desc_q.rs;
		cur_err  = 1'b0;
		last_idx = '0;
		case (desc_q.op)
			lcdnws_pkg::SEQ_BYTE: begin
			end
			lcdnws_pkg::SEQ_INIT: begin
				cur_byte = init_cmd(byte_idx_q[2:0]);
				cur_rs   = 1'b0;
				last_idx = INIT_LAST;
			end
			lcdnws_pkg::SEQ_ERROR: begin
				cur_err  = 1'b1;
				last_idx = ERR_LAST;
				cur_rs   = (byte_idx_q >= ERR_TEXT0);
				if (byte_idx_q == '0) begin
					cur_byte = lcdnws_pkg::LCD_CLEAR;
				end else if (byte_idx_q == 4'd1) begin
					cur_byte = ERR_GOTO;
				end else begin
					cur_byte = err_char(3'(byte_idx_q - ERR_TEXT0));
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		nxt_state.reg_select = cur_rs;
		nxt_state.read_write = 1'b0;
		nxt_state.enable     = (phase_q == PH_HI_STROBE) || (phase_q == PH_LO_STROBE);
		nxt_state.nibble     = (phase_q == PH_HI_STROBE || phase_q == PH_HI_SETTLE)
		                       ? cur_byte[7:4] : cur_byte[3:0];
		nxt_state.hold_ms    = (phase_q == PH_HI_SETTLE) ? '0
		                       : (cur_rs ? data_hold_q : cmd_hold_q);
		nxt_state.error      = cur_err;
	end

	assign adv      = active_q && (!out_valid_q || m_tready);
	assign final_st = (phase_q == PH_LO_SETTLE) && (byte_idx_q == last_idx);
	assign pop      = head_valid && (!active_q || (adv && final_st));

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= head;
		end
		if (adv) begin
			out_data_q <= nxt_state;
			out_last_q <= final_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			phase_q     <= PH_HI_STROBE;
			byte_idx_q  <= '0;
			out_valid_q <= 1'b0;
			cmd_hold_q  <= lcdnws_pkg::CMD_HOLD_RESET;
			data_hold_q <= lcdnws_pkg::DATA_HOLD_RESET;
		end else begin
			if (cfg.we) begin
				case (cfg.index)
					lcdnws_pkg::REG_CMD_HOLD:  cmd_hold_q  <= cfg.data;
					lcdnws_pkg::REG_DATA_HOLD: data_hold_q <= cfg.data;
					default: begin
					end
				endcase
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				if (final_st) begin
					phase_q    <= PH_HI_STROBE;
					byte_idx_q <= '0;
				end else if (phase_q == PH_LO_SETTLE) begin
					phase_q    <= PH_HI_STROBE;
					byte_idx_q <= 4'(byte_idx_q + 1'b1);
				end else begin
					phase_q    <= phase_t'(phase_q + 1'b1);
				end
			end
			if (pop) begin
				active_q <= 1'b1;
			end else if (adv && final_st) begin
				active_q <= 1'b0;
			end
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (phase_q == PH_HI_STROBE && byte_idx_q == '0))
		else $error("sequencer idle with a stale position");

	a_end_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && final_st) |=> (phase_q == PH_HI_STROBE && byte_idx_q == '0 && m_tvalid))
		else $error("request end did not rewind the sequencer");

	a_single_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && desc_q.op == lcdnws_pkg::SEQ_BYTE) |-> (byte_idx_q == '0))
		else $error("single-byte request moved past its byte");

endmodule
`default_nettype wire

// ----- sv/char_lcd_nibble_write_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns character-LCD requests into 4-bit bus states with hold times.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transaction contents
// s_*       in         one request: kind, byte_value, row, column
// m_*       out        one bus state: rs, rw, enable, nibble, hold_ms, error
// cfg_*     in         write of command_hold_ms or data_hold_ms
//
// Each byte becomes four bus states, and the sequencer emits one bus state per
// cycle while the output is not stalled, so a command, data, goto or clear
// request produces four bus states, an init request 20 and a rejected goto 40.
// The front end takes one request per cycle while the four-entry request
// queue has room; a stalled output only backs up into that queue.
// Reset clears the queue and sequencer and loads the hold registers with
// 10 ms (commands) and 3 ms (data).
//
module char_lcd_nibble_write_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [2:0] kind, [10:3] byte_value, [13:11] row, [18:14] column, [23:19] zero
	input  wire logic [23:0] s_tdata,
	// Bus-state stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] reg_select, [1] read_write, [2] enable, [6:3] nibble,
	// [14:7] hold_ms, [15] error
	output logic [15:0]      m_tdata,
	output logic             m_tlast,
	// Configuration writes.
	input  wire logic        cfg_we,
	input  wire logic [lcdnws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lcdnws_pkg::HOLD_W-1:0]    cfg_data
);

	logic                 push;
	lcdnws_pkg::desc_t    push_desc;
	logic                 q_full;
	logic                 pop;
	logic                 head_valid;
	lcdnws_pkg::desc_t    head;
	lcdnws_pkg::cfg_wr_t  cfg;

	// The register index port carries the enum encoding directly.
	assign cfg.we    = cfg_we;
	assign cfg.index = lcdnws_pkg::reg_idx_t'(cfg_index);
	assign cfg.data  = cfg_data;

	// Front end: accepts requests of any kind while the queue has room and queues the ones with a known kind.
	lcdnws_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	lcdnws_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back end: expands a descriptor byte by byte into nibble strobes.
	lcdnws_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire

// ----- dv/char_lcd_nibble_write_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_tb
// Self-checking bench for the character-LCD nibble write sequencer.
// ----------------------------------------------------------------------------
// Requests go into a pending queue. A driver on the falling clock edge plays
// them onto the request stream. A monitor on the rising edge expands every
// accepted request into the bus states that it should produce, using a local
// copy of the hold registers. It then checks each accepted bus state field by
// field against the oldest expected one. A directed set of corner cases comes
// first. Random phases follow under several hold settings and idling patterns.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_tb;

	// Cycles without any transaction before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Quiet time after the last bus state, so that the block is idle before
	// the hold registers are written.
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_PER_PHASE = 46;
	localparam int ROWS = 4;

	// Kinds from here up are not decoded, and the block must drop them.
	localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

	// DDRAM base address of rows 0 to 3, with row 0 in the top byte.
	localparam logic [31:0] ROW_BASE = {8'h00, 8'h40, 8'h14, 8'h54};
	// Power-up sequence: return home, 4-bit two-line mode, display on with a
	// blinking cursor, clear, entry mode increment.
	localparam logic [39:0] INIT_BYTES = {8'h02, 8'h28, 8'h0F, lcdnws_pkg::LCD_CLEAR,
		8'h06};
	// Banner shown after a rejected goto, with the first character in the top byte.
	localparam logic [63:0] ERROR_TEXT = "Error !!";
	localparam logic [7:0]  ERROR_GOTO = lcdnws_pkg::LCD_SET_ADDR + 8'd5;

	// Request fields in their s_tdata order, with kind in the lowest bits.
	typedef struct packed {
		logic [4:0] column;
		logic [2:0] row;
		logic [7:0] byte_value;
		logic [2:0] kind;
	} request_t;

	// One expected bus state together with its end-of-request marker.
	typedef struct packed {
		lcdnws_pkg::bus_state_t bus;
		logic                   last;
	} lcd_state_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	wire                              s_tready;
	logic [23:0]                      s_tdata   = '0;
	wire                              m_tvalid;
	logic                             m_tready  = 1'b0;
	wire  [15:0]                      m_tdata;
	wire                              m_tlast;
	logic                             cfg_we    = 1'b0;
	logic [lcdnws_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lcdnws_pkg::HOLD_W-1:0]    cfg_data  = '0;

	char_lcd_nibble_write_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The bench's own copy of the hold registers. It changes only while the
	// block is idle.
	logic [lcdnws_pkg::HOLD_W-1:0] cmd_hold  = lcdnws_pkg::CMD_HOLD_RESET;
	logic [lcdnws_pkg::HOLD_W-1:0] data_hold = lcdnws_pkg::DATA_HOLD_RESET;

	request_t   pending_reqs[$];
	lcd_state_t states_due[$];

	// Idling percentages for the current phase.
	int idle_pct  = 0;
	int stall_pct = 0;

	int   reqs_queued   = 0;
	int   reqs_accepted = 0;
	int   states_seen   = 0;
	int   bad_gotos     = 0;
	int   ignored_reqs  = 0;
	int   hold_settings = 1;
	int   error_count   = 0;
	int   quiet_cycles  = 0;
	logic req_taken     = 1'b0;

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t ns: mismatch on %s after %0d bus states: got %h, expected %h",
			$time, what, states_seen, got, want);
		error_count++;
	endtask

	// One byte becomes four bus states: enable high and then low on the high
	// nibble, then the same on the low nibble. The first falling edge of
	// enable gets no hold time.
	task automatic push_byte(input logic rs, input logic [7:0] value, input logic err);
		lcd_state_t s;
		logic [lcdnws_pkg::HOLD_W-1:0] hold;
		hold = rs ? data_hold : cmd_hold;
		for (int k = 0; k < 4; k++) begin
			s.bus.reg_select = rs;
			s.bus.read_write = 1'b0;
			s.bus.enable     = (k % 2 == 0);
			s.bus.nibble     = (k < 2) ? value[7:4] : value[3:0];
			s.bus.hold_ms    = (k == 1) ? '0 : hold;
			s.bus.error      = err;
			s.last           = 1'b0;
			states_due.push_back(s);
		end
	endtask

	// Predicts all bus states of one accepted request and marks the final one.
	task automatic expand_request(input request_t r);
		lcd_state_t tail;
		logic [7:0] addr;
		int         start;
		start = states_due.size();
		case (r.kind)
			lcdnws_pkg::KIND_CMD:   push_byte(1'b0, r.byte_value, 1'b0);
			lcdnws_pkg::KIND_DATA:  push_byte(1'b1, r.byte_value, 1'b0);
			lcdnws_pkg::KIND_GOTO: begin
				if (r.row < ROWS && r.column < lcdnws_pkg::COLUMNS) begin
					addr = lcdnws_pkg::LCD_SET_ADDR + ROW_BASE[31 - 8 * r.row -: 8]
						+ {3'b000, r.column};
					push_byte(1'b0, addr, 1'b0);
				end else begin
					// Out-of-range position: clear, home to row 0 column 5, and
					// print the banner. Every state carries the error flag.
					push_byte(1'b0, lcdnws_pkg::LCD_CLEAR, 1'b1);
					push_byte(1'b0, ERROR_GOTO, 1'b1);
					for (int i = 0; i < 8; i++)
						push_byte(1'b1, ERROR_TEXT[63 - 8 * i -: 8], 1'b1);
					bad_gotos++;
				end
			end
			lcdnws_pkg::KIND_INIT: begin
				for (int i = 0; i < 5; i++)
					push_byte(1'b0, INIT_BYTES[39 - 8 * i -: 8], 1'b0);
			end
			lcdnws_pkg::KIND_CLEAR: push_byte(1'b0, lcdnws_pkg::LCD_CLEAR, 1'b0);
			default:    ignored_reqs++;
		endcase
		if (states_due.size() > start) begin
			tail = states_due.pop_back();
			tail.last = 1'b1;
			states_due.push_back(tail);
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: it changes the inputs on the falling edge. A new request goes
	// onto the stream once the previous one has been taken or the stream was
	// idle. The sender idles and the receiver stalls at the phase's rates.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= stall_pct);
			if (!s_tvalid || req_taken) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
					s_tdata  <= {5'b00000, pending_reqs.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: it samples on the rising edge. An accepted request is expanded
	// first, so the expectation is in place even if the block answered at
	// once. Then any accepted bus state is checked against the oldest one.
	// ------------------------------------------------------------------------
	lcdnws_pkg::bus_state_t got;
	lcd_state_t             want;

	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				expand_request(request_t'(s_tdata[18:0]));
				reqs_accepted++;
			end
			if (m_tvalid && m_tready) begin
				got = lcdnws_pkg::bus_state_t'(m_tdata);
				if (states_due.size() == 0) begin
					report_mismatch("unexpected bus state", m_tdata, '0);
				end else begin
					want = states_due.pop_front();
					if (got.reg_select !== want.bus.reg_select)
						report_mismatch("reg_select", 16'(got.reg_select),
							16'(want.bus.reg_select));
					if (got.read_write !== want.bus.read_write)
						report_mismatch("read_write", 16'(got.read_write),
							16'(want.bus.read_write));
					if (got.enable !== want.bus.enable)
						report_mismatch("enable", 16'(got.enable), 16'(want.bus.enable));
					if (got.nibble !== want.bus.nibble)
						report_mismatch("nibble", 16'(got.nibble), 16'(want.bus.nibble));
					if (got.hold_ms !== want.bus.hold_ms)
						report_mismatch("hold_ms", 16'(got.hold_ms), 16'(want.bus.hold_ms));
					if (got.error !== want.bus.error)
						report_mismatch("error", 16'(got.error), 16'(want.bus.error));
					if (m_tlast !== want.last)
						report_mismatch("last", 16'(m_tlast), 16'(want.last));
				end
				states_seen++;
			end
			// Watchdog: a long stretch with no transaction on either stream
			// means that the block has hung.
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("Timed out after %0d quiet cycles, %0d bus states still due",
						quiet_cycles, states_due.size());
					$display("char_lcd_nibble_write_sequencer_tb: errors");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	task automatic queue_request(input request_t r);
		pending_reqs.push_back(r);
		reqs_queued++;
	endtask

	function automatic request_t make_request(input logic [2:0] kind,
			input logic [7:0] value, input logic [2:0] row, input logic [4:0] column);
		request_t r;
		r.kind       = kind;
		r.byte_value = value;
		r.row        = row;
		r.column     = column;
		return r;
	endfunction

	// Mostly well-formed traffic: commands, text and in-range gotos. Rejected
	// gotos, init, clear and undecoded kinds are mixed in. Fields that a kind
	// does not use keep random content.
	function automatic request_t random_request();
		request_t r;
		int       pick;
		r.byte_value = 8'($urandom_range(255));
		r.row        = 3'($urandom_range(7));
		r.column     = 5'($urandom_range(31));
		pick         = $urandom_range(99);
		if (pick < 25) begin
			r.kind = lcdnws_pkg::KIND_CMD;
		end else if (pick < 60) begin
			r.kind = lcdnws_pkg::KIND_DATA;
		end else if (pick < 85) begin
			r.kind = lcdnws_pkg::KIND_GOTO;
			if ($urandom_range(3) != 0) begin
				r.row    = 3'($urandom_range(ROWS - 1));
				r.column = 5'($urandom_range(lcdnws_pkg::COLUMNS - 1));
			end
		end else if (pick < 90) begin
			r.kind = lcdnws_pkg::KIND_INIT;
		end else if (pick < 95) begin
			r.kind = lcdnws_pkg::KIND_CLEAR;
		end else begin
			r.kind = 3'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
		end
		return r;
	endfunction

	// Hold-off: wait until every queued request has been taken and every
	// expected bus state has arrived.
	task automatic wait_all_done();
		while (reqs_accepted != reqs_queued || states_due.size() != 0)
			@(negedge clk);
	endtask

	// Settle before a register write, with a margin after the last bus state.
	task automatic drain_and_settle();
		wait_all_done();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes both hold registers on consecutive cycles. This happens only
	// while the block is idle.
	task automatic set_holds(input logic [lcdnws_pkg::HOLD_W-1:0] cmd_ms,
			input logic [lcdnws_pkg::HOLD_W-1:0] data_ms);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= lcdnws_pkg::REG_CMD_HOLD;
		cfg_data  <= cmd_ms;
		@(negedge clk);
		cfg_index <= lcdnws_pkg::REG_DATA_HOLD;
		cfg_data  <= data_ms;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cmd_hold  = cmd_ms;
		data_hold = data_ms;
		hold_settings++;
	endtask

	// One random phase. Halfway through, the sender holds off until the block
	// has drained completely, then the second half follows.
	task automatic run_phase(input int send_idle, input int recv_stall, input int n);
		idle_pct  = send_idle;
		stall_pct = recv_stall;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				wait_all_done();
			queue_request(random_request());
		end
		drain_and_settle();
	endtask

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed corner cases run with the reset hold times and no idling.
		queue_request(make_request(lcdnws_pkg::KIND_CMD,   8'h00, 3'd0, 5'd0));
		queue_request(make_request(lcdnws_pkg::KIND_CMD,   8'hFF, 3'd7, 5'd31));
		queue_request(make_request(lcdnws_pkg::KIND_DATA,  8'h00, 3'd0, 5'd0));
		queue_request(make_request(lcdnws_pkg::KIND_DATA,  8'hFF, 3'd7, 5'd31));
		queue_request(make_request(lcdnws_pkg::KIND_DATA,  8'hA5, 3'd2, 5'd10));
		queue_request(make_request(lcdnws_pkg::KIND_GOTO,  8'h00, 3'd0, 5'd0));
		queue_request(make_request(lcdnws_pkg::KIND_GOTO,  8'hFF, 3'd1, 5'd19));
		queue_request(make_request(lcdnws_pkg::KIND_GOTO,  8'h00, 3'd2, 5'd0));
		queue_request(make_request(lcdnws_pkg::KIND_GOTO,  8'hFF, 3'd3, 5'd19));
		// Rejected gotos: row just past the last one, column just past the
		// last one, and both fields at their maximum.
		queue_request(make_request(lcdnws_pkg::KIND_GOTO,  8'h00, 3'd4, 5'd0));
		queue_request(make_request(lcdnws_pkg::KIND_GOTO,  8'h00, 3'd0, 5'd20));
		queue_request(make_request(lcdnws_pkg::KIND_GOTO,  8'hFF, 3'd7, 5'd31));
		queue_request(make_request(lcdnws_pkg::KIND_INIT,  8'hFF, 3'd7, 5'd31));
		queue_request(make_request(lcdnws_pkg::KIND_CLEAR, 8'h5A, 3'd5, 5'd21));
		// Undecoded kinds are dropped; the requests after them must still
		// line up.
		queue_request(make_request(KIND_UNUSED_FIRST, 8'hFF, 3'd7, 5'd31));
		queue_request(make_request(KIND_UNUSED_LAST,  8'h00, 3'd0, 5'd0));
		queue_request(make_request(lcdnws_pkg::KIND_DATA,  8'h41, 3'd0, 5'd0));
		drain_and_settle();

		// Random phases: each idling pattern, with both registers at each
		// extreme at least once.
		run_phase(0, 0, RANDOM_PER_PHASE);
		set_holds(8'd0, 8'd255);
		run_phase(71, 0, RANDOM_PER_PHASE);
		set_holds(8'd255, 8'd0);
		run_phase(0, 71, RANDOM_PER_PHASE);
		set_holds(8'($urandom_range(255)), 8'($urandom_range(255)));
		run_phase(19, 19, RANDOM_PER_PHASE);
		set_holds(8'd255, 8'd255);
		run_phase(0, 0, RANDOM_PER_PHASE);

		if (states_due.size() != 0)
			report_mismatch("bus states never produced", 16'(states_due.size()), '0);

		$display("Covered %0d requests (%0d rejected gotos, %0d dropped kinds), %0d bus states,",
			reqs_accepted, bad_gotos, ignored_reqs, states_seen);
		$display("under %0d hold settings and four idling patterns; %0d mismatches.",
			hold_settings, error_count);
		if (error_count == 0) begin
			$display("char_lcd_nibble_write_sequencer_tb: clean");
		end else begin
			$display("char_lcd_nibble_write_sequencer_tb: errors");
		end
		$finish;
	end

endmodule
